>>> hdl/ctok_pkg.sv
`default_nettype none

package ctok_pkg;

	typedef enum logic [3:0] {
		M_IDLE  = 4'd0,
		M_DEC   = 4'd1,
		M_ZERO  = 4'd2,
		M_OCT   = 4'd3,
		M_ZX    = 4'd4,
		M_HEX   = 4'd5,
		M_IDENT = 4'd6,
		M_PAIR  = 4'd7,
		M_HALT  = 4'd8
	} mode_t;

	typedef enum logic [2:0] {
		K_INT   = 3'd0,
		K_ID    = 3'd1,
		K_PUNCT = 3'd2,
		K_END   = 3'd3,
		K_BAD   = 3'd4
	} kind_t;

	localparam int unsigned MAX_RES = 3;
	localparam int unsigned LEN_BITS = 16;
	localparam int unsigned VAL_BITS = 64;

	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_EXCL  = 8'h21;
	localparam logic [7:0] CH_LT    = 8'h3C;
	localparam logic [7:0] CH_EQ    = 8'h3D;
	localparam logic [7:0] CH_GT    = 8'h3E;
	localparam logic [7:0] CH_UNDER = 8'h5F;
	localparam logic [7:0] CH_X_LO  = 8'h78;
	localparam logic [7:0] CH_X_UP  = 8'h58;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_SEVEN = 8'h37;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_A_LO  = 8'h61;
	localparam logic [7:0] CH_F_LO  = 8'h66;
	localparam logic [7:0] CH_Z_LO  = 8'h7A;
	localparam logic [7:0] CH_A_UP  = 8'h41;
	localparam logic [7:0] CH_F_UP  = 8'h46;
	localparam logic [7:0] CH_Z_UP  = 8'h5A;
	localparam logic [7:0] CH_PR_LO = 8'h21;
	localparam logic [7:0] CH_PR_HI = 8'h7E;

endpackage

`default_nettype wire

>>> hdl/c_token_scanner.sv
// c_token_scanner: streaming tokenizer for a small C-like language.
// Input channel (in_valid/in_ready) takes one source byte per beat, with
// last marking the final byte of a text. Output channel (out_valid/out_ready)
// gives one token per beat: kind, start row/col, length, value, overflow,
// and final_res on the last token caused by an input byte.
// A byte is scanned in the cycle it is accepted; its tokens (0 to 3) land in
// a three-entry result buffer and show on the output the next cycle.
// Throughput: one byte per cycle while each byte yields at most one token and
// the receiver is ready; a byte yielding more tokens holds the input while the
// single output port drains the result buffer one token a cycle, as out_ready allows.
// in_ready is high when the buffer is empty, or holds one token that is
// being taken this cycle, so a stalled receiver stops input after one token.
// After the final byte an end token is sent and all scan state returns to
// its reset value, so a new text may follow directly.
// An invalid byte yields an invalid token and the block then takes bytes
// without result until reset. Reset (arst_n low) empties the buffer and
// puts the scanner at row 1, column 1 with no token pending.
`default_nettype none

module c_token_scanner #(
	parameter int unsigned ROW_BITS = 20,
	parameter int unsigned COL_BITS = 16
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [7:0]                    ch,
	input  wire logic                          last,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic [2:0]                         kind,
	output logic [ROW_BITS-1:0]                row,
	output logic [COL_BITS-1:0]                col,
	output logic [ctok_pkg::LEN_BITS-1:0]      length,
	output logic [ctok_pkg::VAL_BITS-1:0]      value,
	output logic                               overflow,
	output logic                               final_res
);
	import ctok_pkg::*;

	typedef struct packed {
		kind_t                 kind;
		logic [ROW_BITS-1:0]   row;
		logic [COL_BITS-1:0]   col;
		logic [LEN_BITS-1:0]   length;
		logic [VAL_BITS-1:0]   value;
		logic                  overflow;
		logic                  final_res;
	} res_t;

	function automatic logic [ROW_BITS-1:0] row_inc(input logic [ROW_BITS-1:0] r);
		return (&r) ? r : r + 1'b1;
	endfunction

	function automatic logic [COL_BITS-1:0] col_inc(input logic [COL_BITS-1:0] c);
		return (&c) ? c : c + 1'b1;
	endfunction

	function automatic logic [LEN_BITS-1:0] len_inc(input logic [LEN_BITS-1:0] l);
		return (&l) ? l : l + 1'b1;
	endfunction

	function automatic res_t mk(input kind_t k, input logic [ROW_BITS-1:0] r,
			input logic [COL_BITS-1:0] c, input logic [LEN_BITS-1:0] l,
			input logic [VAL_BITS-1:0] v, input logic o);
		res_t x;
		x.kind = k;
		x.row = r;
		x.col = c;
		x.length = l;
		x.value = v;
		x.overflow = o;
		x.final_res = 1'b0;
		return x;
	endfunction

	// token that is pending in mode m, closed by the current byte
	function automatic res_t tok_res(input mode_t m, input logic [VAL_BITS-1:0] a,
			input logic o, input logic [ROW_BITS-1:0] r, input logic [COL_BITS-1:0] c,
			input logic [LEN_BITS-1:0] l, input logic [7:0] h);
		res_t x;
		case (m)
			M_IDENT: x = mk(K_ID, r, c, l, '0, 1'b0);
			M_PAIR:  x = mk(K_PUNCT, r, c, l, {{(VAL_BITS-8){1'b0}}, h}, 1'b0);
			default: x = mk(K_INT, r, c, l, a, o);
		endcase
		return x;
	endfunction

	// scan state
	mode_t                 mode_q, mode_d;
	logic [VAL_BITS-1:0]   acc_q, acc_d;
	logic                  ovf_q, ovf_d;
	logic [ROW_BITS-1:0]   tok_row_q, tok_row_d, cur_row_q, cur_row_d;
	logic [COL_BITS-1:0]   tok_col_q, tok_col_d, cur_col_q, cur_col_d;
	logic [LEN_BITS-1:0]   tok_len_q, tok_len_d;
	logic [7:0]            held_q, held_d;

	// result buffer, entry 0 is on the output
	res_t                  buf_q [MAX_RES];
	logic [1:0]            cnt_q;
	res_t                  res_d [MAX_RES];
	logic [1:0]            n_d;

	logic                  in_fire, out_fire;

	// byte classes
	logic                  is_dig, is_oct, is_hexl, is_alpha, is_word, is_space, is_punct;
	logic                  is_pair_ch;
	logic [3:0]            dval;

	// shared accumulate unit
	logic [VAL_BITS+3:0]   prod, sum;
	logic [VAL_BITS-1:0]   acc_upd;
	logic                  ovf_upd;

	assign is_dig   = (ch >= CH_ZERO) && (ch <= CH_NINE);
	assign is_oct   = (ch >= CH_ZERO) && (ch <= CH_SEVEN);
	assign is_hexl  = ((ch >= CH_A_LO) && (ch <= CH_F_LO)) || ((ch >= CH_A_UP) && (ch <= CH_F_UP));
	assign is_alpha = ((ch >= CH_A_LO) && (ch <= CH_Z_LO)) || ((ch >= CH_A_UP) && (ch <= CH_Z_UP));
	assign is_word  = is_alpha || is_dig || (ch == CH_UNDER);
	assign is_space = (ch == CH_SPACE) || ((ch >= CH_TAB) && (ch <= CH_CR));
	assign is_punct = (ch >= CH_PR_LO) && (ch <= CH_PR_HI) && !is_alpha && !is_dig;
	assign is_pair_ch = (ch == CH_EQ) || (ch == CH_EXCL) || (ch == CH_LT) || (ch == CH_GT);
	// letters a-f / A-F have low nibble 1..6
	assign dval = is_dig ? ch[3:0] : ch[3:0] + 4'd9;

	always_comb begin
		case (mode_q)
			M_DEC:         prod = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0};
			M_ZX, M_HEX:   prod = {acc_q, 4'b0000};
			default:       prod = {1'b0, acc_q, 3'b000};
		endcase
		sum = prod + {{VAL_BITS{1'b0}}, dval};
		if (ovf_q) begin
			acc_upd = acc_q;
			ovf_upd = 1'b1;
		end else if (|sum[VAL_BITS+3:VAL_BITS]) begin
			acc_upd = '1;
			ovf_upd = 1'b1;
		end else begin
			acc_upd = sum[VAL_BITS-1:0];
			ovf_upd = 1'b0;
		end
	end

	always_comb begin
		logic fresh;
		mode_d = mode_q;
		acc_d = acc_q;
		ovf_d = ovf_q;
		tok_row_d = tok_row_q;
		tok_col_d = tok_col_q;
		tok_len_d = tok_len_q;
		cur_row_d = cur_row_q;
		cur_col_d = cur_col_q;
		held_d = held_q;
		n_d = 2'd0;
		fresh = 1'b0;
		for (int i = 0; i < MAX_RES; i++) begin
			res_d[i] = '0;
		end

		if (mode_q != M_HALT) begin
			// continue or close the pending token
			case (mode_q)
				M_IDLE: fresh = 1'b1;
				M_DEC: begin
					if (is_dig) begin
						acc_d = acc_upd;
						ovf_d = ovf_upd;
					end else begin
						fresh = 1'b1;
					end
				end
				M_ZERO: begin
					if ((ch == CH_X_LO) || (ch == CH_X_UP)) begin
						mode_d = M_ZX;
					end else if (is_oct) begin
						mode_d = M_OCT;
						acc_d = acc_upd;
						ovf_d = ovf_upd;
					end else begin
						fresh = 1'b1;
					end
				end
				M_OCT: begin
					if (is_oct) begin
						acc_d = acc_upd;
						ovf_d = ovf_upd;
					end else begin
						fresh = 1'b1;
					end
				end
				M_ZX, M_HEX: begin
					if (is_dig || is_hexl) begin
						mode_d = M_HEX;
						acc_d = acc_upd;
						ovf_d = ovf_upd;
					end else begin
						fresh = 1'b1;
					end
				end
				M_IDENT: fresh = !is_word;
				M_PAIR: begin
					if (ch == CH_EQ) begin
						res_d[n_d] = mk(K_PUNCT, tok_row_q, tok_col_q, len_inc(tok_len_q),
							{{(VAL_BITS-16){1'b0}}, CH_EQ, held_q}, 1'b0);
						n_d = n_d + 2'd1;
						mode_d = M_IDLE;
					end else begin
						fresh = 1'b1;
					end
				end
				default: fresh = 1'b0;
			endcase

			if (!fresh) begin
				tok_len_d = len_inc(tok_len_q);
				cur_col_d = col_inc(cur_col_q);
			end else begin
				if (mode_q != M_IDLE) begin
					res_d[n_d] = tok_res(mode_q, acc_q, ovf_q, tok_row_q, tok_col_q,
						tok_len_q, held_q);
					n_d = n_d + 2'd1;
				end
				mode_d = M_IDLE;
				if (is_space) begin
					if (ch == CH_NL) begin
						cur_row_d = row_inc(cur_row_q);
						cur_col_d = {{(COL_BITS-1){1'b0}}, 1'b1};
					end else begin
						cur_col_d = col_inc(cur_col_q);
					end
				end else if (is_dig || is_alpha || (ch == CH_UNDER) || (is_punct && is_pair_ch))
						begin
					tok_row_d = cur_row_q;
					tok_col_d = cur_col_q;
					tok_len_d = {{(LEN_BITS-1){1'b0}}, 1'b1};
					acc_d = {{(VAL_BITS-4){1'b0}}, ch[3:0]};
					ovf_d = 1'b0;
					cur_col_d = col_inc(cur_col_q);
					if (is_dig) begin
						mode_d = (ch == CH_ZERO) ? M_ZERO : M_DEC;
					end else if (is_pair_ch) begin
						mode_d = M_PAIR;
						held_d = ch;
						acc_d = '0;
					end else begin
						mode_d = M_IDENT;
						acc_d = '0;
					end
				end else if (is_punct) begin
					res_d[n_d] = mk(K_PUNCT, cur_row_q, cur_col_q,
						{{(LEN_BITS-1){1'b0}}, 1'b1}, {{(VAL_BITS-8){1'b0}}, ch}, 1'b0);
					n_d = n_d + 2'd1;
					cur_col_d = col_inc(cur_col_q);
				end else begin
					res_d[n_d] = mk(K_BAD, cur_row_q, cur_col_q,
						{{(LEN_BITS-1){1'b0}}, 1'b1}, {{(VAL_BITS-8){1'b0}}, ch}, 1'b0);
					n_d = n_d + 2'd1;
					mode_d = M_HALT;
				end
			end

			// end of text: implied newline, end token, back to reset state
			if (last && (mode_d != M_HALT)) begin
				if (ch != CH_NL) begin
					if (mode_d != M_IDLE) begin
						res_d[n_d] = tok_res(mode_d, acc_d, ovf_d, tok_row_d, tok_col_d,
							tok_len_d, held_d);
						n_d = n_d + 2'd1;
					end
					cur_row_d = row_inc(cur_row_d);
					cur_col_d = {{(COL_BITS-1){1'b0}}, 1'b1};
				end
				res_d[n_d] = mk(K_END, cur_row_d, cur_col_d, '0, '0, 1'b0);
				n_d = n_d + 2'd1;
				mode_d = M_IDLE;
				acc_d = '0;
				ovf_d = 1'b0;
				tok_row_d = {{(ROW_BITS-1){1'b0}}, 1'b1};
				tok_col_d = {{(COL_BITS-1){1'b0}}, 1'b1};
				tok_len_d = '0;
				cur_row_d = {{(ROW_BITS-1){1'b0}}, 1'b1};
				cur_col_d = {{(COL_BITS-1){1'b0}}, 1'b1};
				held_d = '0;
			end

			if (n_d != 2'd0) begin
				res_d[n_d - 2'd1].final_res = 1'b1;
			end
		end
	end

	assign out_valid = (cnt_q != 2'd0);
	assign out_fire  = out_valid && out_ready;
	assign in_ready  = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && out_ready);
	assign in_fire   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_IDLE;
			acc_q <= '0;
			ovf_q <= 1'b0;
			tok_row_q <= {{(ROW_BITS-1){1'b0}}, 1'b1};
			tok_col_q <= {{(COL_BITS-1){1'b0}}, 1'b1};
			tok_len_q <= '0;
			cur_row_q <= {{(ROW_BITS-1){1'b0}}, 1'b1};
			cur_col_q <= {{(COL_BITS-1){1'b0}}, 1'b1};
			held_q <= '0;
		end else if (in_fire) begin
			mode_q <= mode_d;
			acc_q <= acc_d;
			ovf_q <= ovf_d;
			tok_row_q <= tok_row_d;
			tok_col_q <= tok_col_d;
			tok_len_q <= tok_len_d;
			cur_row_q <= cur_row_d;
			cur_col_q <= cur_col_d;
			held_q <= held_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (in_fire) begin
			cnt_q <= n_d;
		end else if (out_fire) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			for (int i = 0; i < MAX_RES; i++) begin
				buf_q[i] <= res_d[i];
			end
		end else if (out_fire) begin
			for (int i = 0; i < MAX_RES - 1; i++) begin
				buf_q[i] <= buf_q[i+1];
			end
		end
	end

	assign kind      = buf_q[0].kind;
	assign row       = buf_q[0].row;
	assign col       = buf_q[0].col;
	assign length    = buf_q[0].length;
	assign value     = buf_q[0].value;
	assign overflow  = buf_q[0].overflow;
	assign final_res = buf_q[0].final_res;

	a_halt_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == M_HALT) |=> (mode_q == M_HALT))
		else $error("scanner left halt without reset");

	a_halt_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && (mode_q == M_HALT)) |=> (cnt_q == 2'd0))
		else $error("result produced while halted");

	a_final_is_tail: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && buf_q[0].final_res) |-> (cnt_q == 2'd1))
		else $error("final_res set on a token that is not the last of its byte");

	a_text_end_resets: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && last && (mode_q != M_HALT)) |=> ((mode_q == M_HALT) ||
		((mode_q == M_IDLE) && (cur_row_q == 1) && (cur_col_q == 1))))
		else $error("scan state not restored after end of text");

endmodule

`default_nettype wire

>>> tb/c_token_scanner_chk.sv
`default_nettype none

module c_token_scanner_chk #(
	parameter int unsigned ROW_BITS = 20,
	parameter int unsigned COL_BITS = 16
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               in_valid,
	input  wire logic                               in_ready,
	input  wire logic [7:0]                         ch,
	input  wire logic                               last,
	input  wire logic                               out_valid,
	input  wire logic                               out_ready,
	input  wire logic [2:0]                         kind,
	input  wire logic [ROW_BITS-1:0]                row,
	input  wire logic [COL_BITS-1:0]                col,
	input  wire logic [ctok_pkg::LEN_BITS-1:0]      length,
	input  wire logic [ctok_pkg::VAL_BITS-1:0]      value,
	input  wire logic                               overflow,
	input  wire logic                               final_res,
	output int                                      fails,
	output int                                      pending
);
	import ctok_pkg::*;

	localparam logic [ROW_BITS-1:0] ROW_TOP = '1;
	localparam logic [COL_BITS-1:0] COL_TOP = '1;
	localparam logic [LEN_BITS-1:0] LEN_TOP = '1;
	localparam logic [VAL_BITS-1:0] VAL_TOP = '1;

	typedef struct packed {
		kind_t                 k;
		logic [ROW_BITS-1:0]   r;
		logic [COL_BITS-1:0]   c;
		logic [LEN_BITS-1:0]   n;
		logic [VAL_BITS-1:0]   v;
		logic                  ovf;
		logic                  fin;
	} token_t;

	token_t tokens_due[$];
	token_t step_toks[$];
	int     nfail;

	// scanner state
	mode_t                 scan_mode;
	logic [VAL_BITS-1:0]   acc;
	logic                  acc_ovf;
	logic [ROW_BITS-1:0]   tok_row;
	logic [COL_BITS-1:0]   tok_col;
	logic [LEN_BITS-1:0]   tok_len;
	logic [ROW_BITS-1:0]   cur_row;
	logic [COL_BITS-1:0]   cur_col;
	logic [7:0]            held;

	function automatic bit is_dig(input logic [7:0] c);
		return c >= CH_ZERO && c <= CH_NINE;
	endfunction

	function automatic bit is_alpha(input logic [7:0] c);
		return (c >= CH_A_LO && c <= CH_Z_LO) || (c >= CH_A_UP && c <= CH_Z_UP);
	endfunction

	function automatic bit is_word(input logic [7:0] c);
		return is_alpha(c) || is_dig(c) || c == CH_UNDER;
	endfunction

	function automatic bit is_ws(input logic [7:0] c);
		return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
	endfunction

	function automatic bit is_punc(input logic [7:0] c);
		return c >= CH_PR_LO && c <= CH_PR_HI && !is_alpha(c) && !is_dig(c);
	endfunction

	function automatic int hex_of(input logic [7:0] c);
		if (is_dig(c))
			return int'(c - CH_ZERO);
		if (c >= CH_A_LO && c <= CH_F_LO)
			return int'(c - CH_A_LO) + 10;
		if (c >= CH_A_UP && c <= CH_F_UP)
			return int'(c - CH_A_UP) + 10;
		return -1;
	endfunction

	task automatic clear_scan();
		scan_mode = M_IDLE;
		acc = '0;
		acc_ovf = 1'b0;
		tok_row = ROW_BITS'(1);
		tok_col = COL_BITS'(1);
		tok_len = '0;
		cur_row = ROW_BITS'(1);
		cur_col = COL_BITS'(1);
		held = '0;
	endtask

	task automatic bump_col();
		if (cur_col != COL_TOP)
			cur_col++;
	endtask

	task automatic grow_tok();
		if (tok_len != LEN_TOP)
			tok_len++;
		bump_col();
	endtask

	task automatic add_digit(input logic [VAL_BITS-1:0] base, input logic [VAL_BITS-1:0] d);
		if (!acc_ovf) begin
			if (acc > (VAL_TOP - d) / base) begin
				acc = VAL_TOP;
				acc_ovf = 1'b1;
			end else begin
				acc = acc * base + d;
			end
		end
	endtask

	task automatic open_tok(input mode_t m);
		scan_mode = m;
		tok_row = cur_row;
		tok_col = cur_col;
		tok_len = LEN_BITS'(1);
		acc = '0;
		acc_ovf = 1'b0;
		bump_col();
	endtask

	task automatic queue_tok(input kind_t k, input logic [ROW_BITS-1:0] r,
			input logic [COL_BITS-1:0] c, input logic [LEN_BITS-1:0] n,
			input logic [VAL_BITS-1:0] v, input logic ovf);
		token_t t;
		t.k = k;
		t.r = r;
		t.c = c;
		t.n = n;
		t.v = v;
		t.ovf = ovf;
		t.fin = 1'b0;
		if (step_toks.size() < MAX_RES)
			step_toks.push_back(t);
	endtask

	task automatic close_int();
		queue_tok(K_INT, tok_row, tok_col, tok_len, acc, acc_ovf);
		scan_mode = M_IDLE;
	endtask

	task automatic scan_byte(input logic [7:0] c);
		bit fresh;
		int h;
		fresh = 1'b1;
		h = hex_of(c);
		case (scan_mode)
			M_DEC: begin
				if (is_dig(c)) begin
					add_digit(64'd10, VAL_BITS'(c - CH_ZERO));
					grow_tok();
					fresh = 1'b0;
				end else begin
					close_int();
				end
			end
			M_ZERO: begin
				if (c == CH_X_LO || c == CH_X_UP) begin
					scan_mode = M_ZX;
					grow_tok();
					fresh = 1'b0;
				end else if (c >= CH_ZERO && c <= CH_SEVEN) begin
					scan_mode = M_OCT;
					add_digit(64'd8, VAL_BITS'(c - CH_ZERO));
					grow_tok();
					fresh = 1'b0;
				end else begin
					close_int();
				end
			end
			M_OCT: begin
				if (c >= CH_ZERO && c <= CH_SEVEN) begin
					add_digit(64'd8, VAL_BITS'(c - CH_ZERO));
					grow_tok();
					fresh = 1'b0;
				end else begin
					close_int();
				end
			end
			M_ZX, M_HEX: begin
				if (h >= 0) begin
					scan_mode = M_HEX;
					add_digit(64'd16, VAL_BITS'(h));
					grow_tok();
					fresh = 1'b0;
				end else begin
					close_int();
				end
			end
			M_IDENT: begin
				if (is_word(c)) begin
					grow_tok();
					fresh = 1'b0;
				end else begin
					queue_tok(K_ID, tok_row, tok_col, tok_len, '0, 1'b0);
					scan_mode = M_IDLE;
				end
			end
			M_PAIR: begin
				if (c == CH_EQ) begin
					grow_tok();
					queue_tok(K_PUNCT, tok_row, tok_col, tok_len,
						{48'd0, CH_EQ, held}, 1'b0);
					scan_mode = M_IDLE;
					fresh = 1'b0;
				end else begin
					queue_tok(K_PUNCT, tok_row, tok_col, tok_len, {56'd0, held}, 1'b0);
					scan_mode = M_IDLE;
				end
			end
			M_IDLE: ;
			default: fresh = 1'b0;
		endcase

		if (fresh) begin
			if (is_ws(c)) begin
				if (c == CH_NL) begin
					if (cur_row != ROW_TOP)
						cur_row++;
					cur_col = COL_BITS'(1);
				end else begin
					bump_col();
				end
			end else if (is_dig(c)) begin
				open_tok(c == CH_ZERO ? M_ZERO : M_DEC);
				acc = VAL_BITS'(c - CH_ZERO);
			end else if (is_alpha(c) || c == CH_UNDER) begin
				open_tok(M_IDENT);
			end else if (is_punc(c)) begin
				if (c == CH_EQ || c == CH_EXCL || c == CH_LT || c == CH_GT) begin
					open_tok(M_PAIR);
					held = c;
				end else begin
					queue_tok(K_PUNCT, cur_row, cur_col, LEN_BITS'(1), {56'd0, c}, 1'b0);
					bump_col();
				end
			end else begin
				queue_tok(K_BAD, cur_row, cur_col, LEN_BITS'(1), {56'd0, c}, 1'b0);
				scan_mode = M_HALT;
			end
		end
	endtask

	task automatic tokenize_byte(input logic [7:0] c, input logic l);
		token_t t;
		int n;
		step_toks.delete();
		if (scan_mode != M_HALT) begin
			scan_byte(c);
			// end of text: implied newline closes any open token
			if (l && scan_mode != M_HALT) begin
				if (c != CH_NL)
					scan_byte(CH_NL);
				queue_tok(K_END, cur_row, cur_col, '0, '0, 1'b0);
				clear_scan();
			end
			n = step_toks.size();
			for (int i = 0; i < n; i++) begin
				t = step_toks[i];
				t.fin = (i == n - 1);
				tokens_due.push_back(t);
			end
		end
	endtask

	task automatic check_token();
		token_t t;
		bit bad;
		bad = 1'b0;
		if (tokens_due.size() == 0) begin
			$error("unexpected token beat: kind %0d row %0d col %0d value %0h",
				kind, row, col, value);
			nfail++;
		end else begin
			t = tokens_due.pop_front();
			if (kind !== t.k) begin
				$error("kind: expected %0d, got %0d", t.k, kind);
				bad = 1'b1;
			end
			if (row !== t.r) begin
				$error("row: expected %0d, got %0d", t.r, row);
				bad = 1'b1;
			end
			if (col !== t.c) begin
				$error("col: expected %0d, got %0d", t.c, col);
				bad = 1'b1;
			end
			if (length !== t.n) begin
				$error("length: expected %0d, got %0d", t.n, length);
				bad = 1'b1;
			end
			if (value !== t.v) begin
				$error("value: expected %0h, got %0h", t.v, value);
				bad = 1'b1;
			end
			if (overflow !== t.ovf) begin
				$error("overflow: expected %0b, got %0b", t.ovf, overflow);
				bad = 1'b1;
			end
			if (final_res !== t.fin) begin
				$error("final_res: expected %0b, got %0b", t.fin, final_res);
				bad = 1'b1;
			end
			if (bad)
				nfail++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_scan();
			tokens_due.delete();
			nfail = 0;
			fails <= 0;
			pending <= 0;
		end else begin
			// a token beat never comes from the byte taken at the same edge
			if (out_valid && out_ready)
				check_token();
			if (in_valid && in_ready)
				tokenize_byte(ch, last);
			fails <= nfail;
			pending <= tokens_due.size();
		end
	end

endmodule

`default_nettype wire

>>> tb/c_token_scanner_tb.sv
`default_nettype none

module c_token_scanner_tb;
	import ctok_pkg::*;

	localparam int unsigned ROW_W = 20;
	localparam int unsigned COL_W = 16;
	localparam int STALL_LIMIT = 2000;
	localparam int RAND_ITEMS = 360;
	localparam int HOLD_CYCLES = 60;
	localparam int LONG_NAME = 40;
	localparam logic [7:0] CH_PLUS = 8'h2B;

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_ready;
	logic [7:0]            ch;
	logic                  last;
	logic                  out_valid;
	logic                  out_ready;
	logic [2:0]            kind;
	logic [ROW_W-1:0]      row;
	logic [COL_W-1:0]      col;
	logic [LEN_BITS-1:0]   length;
	logic [VAL_BITS-1:0]   value;
	logic                  overflow;
	logic                  final_res;
	int                    fails;
	int                    pending;

	logic [7:0] txt[$];
	int         n_items;
	int         stall_cnt;
	bit         quiet;
	bit         hold_req;

	c_token_scanner #(
		.ROW_BITS(ROW_W),
		.COL_BITS(COL_W)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.ch(ch),
		.last(last),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.kind(kind),
		.row(row),
		.col(col),
		.length(length),
		.value(value),
		.overflow(overflow),
		.final_res(final_res)
	);

	c_token_scanner_chk #(
		.ROW_BITS(ROW_W),
		.COL_BITS(COL_W)
	) u_chk (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.ch(ch),
		.last(last),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.kind(kind),
		.row(row),
		.col(col),
		.length(length),
		.value(value),
		.overflow(overflow),
		.final_res(final_res),
		.fails(fails),
		.pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic logic [7:0] rand_id_start();
		int p;
		p = $urandom_range(0, 52);
		if (p < 26)
			return CH_A_LO + 8'(p);
		if (p < 52)
			return CH_A_UP + 8'(p - 26);
		return CH_UNDER;
	endfunction

	function automatic logic [7:0] rand_word_char();
		int p;
		p = $urandom_range(0, 62);
		if (p < 53)
			return rand_id_start();
		return CH_ZERO + 8'(p - 53);
	endfunction

	function automatic logic [7:0] rand_hex_char();
		int p;
		p = $urandom_range(0, 21);
		if (p < 10)
			return CH_ZERO + 8'(p);
		if (p < 16)
			return CH_A_LO + 8'(p - 10);
		return CH_A_UP + 8'(p - 16);
	endfunction

	function automatic bit alnum(input logic [7:0] c);
		return (c >= CH_ZERO && c <= CH_NINE) || (c >= CH_A_LO && c <= CH_Z_LO) ||
			(c >= CH_A_UP && c <= CH_Z_UP);
	endfunction

	task automatic send_byte(input logic [7:0] c, input logic l);
		in_valid <= 1'b1;
		ch <= c;
		last <= l;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		n_items++;
		if (!quiet && !hold_req && $urandom_range(0, 7) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
	endtask

	// send the buffered text, last flag on its final byte
	task automatic send_text();
		int n;
		n = txt.size();
		for (int i = 0; i < n; i++)
			send_byte(txt[i], i == n - 1);
		txt.delete();
	endtask

	task automatic send_str(input string s);
		for (int i = 0; i < s.len(); i++)
			txt.push_back(s[i]);
		send_text();
	endtask

	task automatic add_token();
		int n;
		logic [7:0] c;
		case ($urandom_range(0, 9))
			0: begin
				n = ($urandom_range(0, 5) == 0) ? $urandom_range(18, 24) : $urandom_range(1, 5);
				txt.push_back(CH_ZERO + 8'($urandom_range(1, 9)));
				repeat (n - 1) txt.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
			end
			1: begin
				n = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 24) : $urandom_range(1, 4);
				txt.push_back(CH_ZERO);
				repeat (n) txt.push_back(CH_ZERO + 8'($urandom_range(0, 7)));
			end
			2: begin
				n = ($urandom_range(0, 5) == 0) ? $urandom_range(15, 18) : $urandom_range(1, 4);
				txt.push_back(CH_ZERO);
				txt.push_back($urandom_range(0, 1) ? CH_X_UP : CH_X_LO);
				repeat (n) txt.push_back(rand_hex_char());
			end
			3: begin
				txt.push_back(CH_ZERO);
				if ($urandom_range(0, 1))
					txt.push_back($urandom_range(0, 1) ? CH_X_UP : CH_X_LO);
			end
			4, 5: begin
				txt.push_back(rand_id_start());
				repeat ($urandom_range(0, 8)) txt.push_back(rand_word_char());
			end
			6: begin
				case ($urandom_range(0, 3))
					0: txt.push_back(CH_EQ);
					1: txt.push_back(CH_EXCL);
					2: txt.push_back(CH_LT);
					default: txt.push_back(CH_GT);
				endcase
				if ($urandom_range(0, 1))
					txt.push_back(CH_EQ);
			end
			7: begin
				do
					c = 8'($urandom_range(CH_PR_LO, CH_PR_HI));
				while (alnum(c) || c == CH_UNDER);
				txt.push_back(c);
			end
			8: begin
				// number running straight into a name
				repeat ($urandom_range(1, 3)) txt.push_back(CH_ZERO + 8'($urandom_range(1, 9)));
				repeat ($urandom_range(1, 3)) txt.push_back(rand_id_start());
			end
			default: begin
				repeat ($urandom_range(1, 6)) begin
					if ($urandom_range(0, 4) == 0)
						txt.push_back(8'($urandom_range(CH_TAB, CH_CR)));
					else
						txt.push_back(8'($urandom_range(CH_SPACE, CH_PR_HI)));
				end
			end
		endcase
	endtask

	task automatic add_sep();
		case ($urandom_range(0, 7))
			0, 1: ;
			2, 3: txt.push_back(CH_SPACE);
			4: txt.push_back(CH_NL);
			5: txt.push_back(CH_TAB);
			6: txt.push_back(CH_CR);
			default: txt.push_back(CH_TAB + 8'($urandom_range(2, 3)));
		endcase
	endtask

	task automatic add_text();
		repeat ($urandom_range(1, 10)) begin
			add_token();
			add_sep();
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
		@(posedge clk);
	endtask

	// receiver side
	initial begin
		out_ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_req) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end else if (!quiet && $urandom_range(0, 3) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end else begin
				out_ready <= 1'b1;
				repeat ($urandom_range(1, 16)) @(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				stall_cnt <= 0;
			end else if (stall_cnt >= STALL_LIMIT) begin
				$display("Some tests failed");
				$finish;
			end else begin
				stall_cnt <= stall_cnt + 1;
			end
		end
	end

	initial begin
		bit held_off;
		bit paused;
		logic [7:0] bad;
		held_off = 1'b0;
		paused = 1'b0;
		quiet = 1'b0;
		hold_req = 1'b0;
		n_items = 0;
		stall_cnt = 0;
		in_valid <= 1'b0;
		ch <= '0;
		last <= 1'b0;
		arst_n <= 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// hex, octal stop, bare prefix, pairs, digits into letters
		send_str("0xAf 09 0X<=!=\n");
		send_str("z_9\t12ab>===~");

		while (n_items < RAND_ITEMS) begin
			if (!held_off && n_items >= 150) begin
				held_off = 1'b1;
				hold_req = 1'b1;
			end
			if (!paused && n_items >= 300) begin
				paused = 1'b1;
				drain();
			end
			add_text();
			send_text();
		end

		quiet = 1'b1;
		// long name, then a lone punctuator
		txt.push_back(CH_A_LO);
		repeat (LONG_NAME) txt.push_back(CH_UNDER);
		txt.push_back(CH_SPACE);
		txt.push_back(CH_PLUS);
		send_text();
		repeat (2) begin
			add_text();
			send_text();
		end

		// bad byte halts the scanner for the rest of the run
		case ($urandom_range(0, 3))
			0: bad = 8'($urandom_range(128, 255));
			1: bad = 8'($urandom_range(0, 8));
			2: bad = 8'($urandom_range(14, 31));
			default: bad = 8'h7F;
		endcase
		send_byte(CH_A_LO, 1'b0);
		send_byte(CH_A_LO + 8'd1, 1'b0);
		send_byte(bad, 1'($urandom_range(0, 1)));
		send_byte(8'hFF, 1'b0);
		send_byte(8'h00, 1'b1);
		send_byte(8'($urandom_range(0, 255)), 1'b1);

		drain();
		repeat (10) @(posedge clk);
		if (fails == 0 && pending == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

`default_nettype wire

>>> sim.f
hdl/ctok_pkg.sv
hdl/c_token_scanner.sv
tb/c_token_scanner_chk.sv
tb/c_token_scanner_tb.sv
